// ===== rtl/wsd_pkg.sv =====
// Shared types and constants for the wheel speed / distance tracker.
// No dependencies; used by every module of the block by scoped names.
package wsd_pkg;

    localparam int unsigned RingDepth = 4;
    localparam int unsigned RingIdxW  = 2;
    localparam int unsigned TicksW    = 16;
    localparam int unsigned SumW      = 18;
    localparam int unsigned CircW     = 12;
    localparam int unsigned SpeedW    = 24;
    localparam int unsigned SecsW     = 24;
    localparam int unsigned DistW     = 48;
    localparam int unsigned RevW      = 32;
    localparam int unsigned SpeedShift = 12;   // 4 * 1024
    localparam int unsigned DivW      = 24;
    localparam int unsigned DivCntW   = 5;

    localparam logic [TicksW-1:0] MaxRotationTicks = 16'd10240;
    localparam logic [TicksW-1:0] TimeoutThreshold = MaxRotationTicks - 16'd1;
    localparam logic [TicksW-1:0] TimeoutAdvance   = 16'd10240;  // 10 s of ticks
    localparam logic [SpeedW-1:0] SpeedMax         = 24'hFFFFFF;
    localparam logic [CircW-1:0]  CircReset        = 12'd2100;
    localparam logic [DivCntW-1:0] DivSteps        = 5'd24;

    // command codes carried in tuser
    localparam logic CmdRevolution = 1'b0;
    localparam logic CmdSpeedReset = 1'b1;

    // APB register map (word index taken from paddr[2])
    localparam logic RegWheelCircumference = 1'b0;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic speed_div_start;
        logic speed_from_div;
        logic speed_saturate;
        logic peak_update;
        logic mean_div_start;
        logic mean_from_div;
        logic mean_zero;
        logic mean_saturate;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_reset_cmd;
        logic timeout;
        logic running;
        logic sum_zero;
        logic secs_zero;
        logic mean_over;
        logic div_done;
    } dp_status_t;

endpackage

// ===== rtl/wsd_div.sv =====
// Restoring divider, one quotient bit per cycle, 24 steps.
// Depends on wsd_pkg.
module wsd_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [wsd_pkg::DivW-1:0]       dividend,
    input  logic [wsd_pkg::DivW-1:0]       init_rem,   // must be below divisor
    input  logic [wsd_pkg::DivW-1:0]       divisor,
    output logic [wsd_pkg::DivW-1:0]       quotient,
    output logic                           done
);

    logic [wsd_pkg::DivW-1:0]    rem_reg, rem_next;
    logic [wsd_pkg::DivW-1:0]    quo_reg, quo_next;
    logic [wsd_pkg::DivW-1:0]    dvs_reg;
    logic [wsd_pkg::DivCntW-1:0] cnt_reg, cnt_next;
    logic [wsd_pkg::DivW:0]      rem_sh;
    logic [wsd_pkg::DivW+1:0]    diff;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[wsd_pkg::DivW-1]};
        diff     = {1'b0, rem_sh} - {2'b00, dvs_reg};
        rem_next = diff[wsd_pkg::DivW+1] ? rem_sh[wsd_pkg::DivW-1:0]
                                         : diff[wsd_pkg::DivW-1:0];
        quo_next = {quo_reg[wsd_pkg::DivW-2:0], ~diff[wsd_pkg::DivW+1]};
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = wsd_pkg::DivSteps;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - wsd_pkg::DivCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= init_rem;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == '0);

endmodule

// ===== rtl/wsd_dp.sv =====
// Datapath: revolution ring, counters, distances, speeds and output register.
// Depends on wsd_pkg and wsd_div.
module wsd_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wsd_pkg::dp_cmd_t                 cmd,
    output wsd_pkg::dp_status_t              status,
    input  logic [wsd_pkg::CircW-1:0]        circumference,
    input  logic                             in_command,
    input  logic [wsd_pkg::TicksW-1:0]       in_rotation_ticks,
    input  logic                             in_trip_running,
    input  logic [wsd_pkg::SecsW-1:0]        in_trip_seconds,
    output logic [wsd_pkg::SpeedW-1:0]       current_speed,
    output logic [wsd_pkg::SpeedW-1:0]       max_speed,
    output logic [wsd_pkg::SpeedW-1:0]       average_speed,
    output logic [wsd_pkg::DistW-1:0]        trip_distance,
    output logic [wsd_pkg::DistW-1:0]        total_distance,
    output logic [wsd_pkg::RevW-1:0]         revolution_count,
    output logic [wsd_pkg::TicksW-1:0]       wheel_clock
);

    // captured item
    logic                         cmd_reg;
    logic [wsd_pkg::TicksW-1:0]   ticks_reg;
    logic                         running_reg;
    logic [wsd_pkg::SecsW-1:0]    secs_reg;

    logic [wsd_pkg::TicksW-1:0]   ring_reg  [wsd_pkg::RingDepth];
    logic [wsd_pkg::TicksW-1:0]   ring_next [wsd_pkg::RingDepth];
    logic [wsd_pkg::RingIdxW-1:0] pos_reg, pos_next;
    logic [wsd_pkg::SpeedW-1:0]   speed_reg, speed_next;
    logic [wsd_pkg::SpeedW-1:0]   peak_reg, peak_next;
    logic [wsd_pkg::SpeedW-1:0]   mean_reg, mean_next;
    logic [wsd_pkg::DistW-1:0]    trip_reg, trip_next;
    logic [wsd_pkg::DistW-1:0]    total_reg, total_next;
    logic [wsd_pkg::RevW-1:0]     rev_reg, rev_next;
    logic [wsd_pkg::TicksW-1:0]   clock_reg, clock_next;

    logic [wsd_pkg::SumW-1:0]     ring_sum;
    logic                         timeout;
    logic                         div_start;
    logic [wsd_pkg::DivW-1:0]     div_dividend;
    logic [wsd_pkg::DivW-1:0]     div_init_rem;
    logic [wsd_pkg::DivW-1:0]     div_divisor;
    logic [wsd_pkg::DivW-1:0]     div_quotient;
    logic                         div_done;

    always_comb
    begin
        ring_sum = '0;
        for (int i = 0; i < wsd_pkg::RingDepth; i++)
        begin
            ring_sum = ring_sum + wsd_pkg::SumW'(ring_reg[i]);
        end
    end

    assign timeout = (ticks_reg >= wsd_pkg::TimeoutThreshold);

    // one divider shared by speed and mean; mean starts from the high half
    // of trip distance, known to be below the seconds count
    assign div_start    = cmd.speed_div_start | cmd.mean_div_start;
    assign div_dividend = cmd.mean_div_start ? trip_reg[wsd_pkg::DivW-1:0]
                                             : {circumference, {wsd_pkg::SpeedShift{1'b0}}};
    assign div_init_rem = cmd.mean_div_start ? trip_reg[wsd_pkg::DistW-1:wsd_pkg::DivW]
                                             : '0;
    assign div_divisor  = cmd.mean_div_start ? secs_reg
                                             : wsd_pkg::DivW'(ring_sum);

    wsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .init_rem (div_init_rem),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    always_comb
    begin
        status.is_reset_cmd = (cmd_reg == wsd_pkg::CmdSpeedReset);
        status.timeout      = timeout;
        status.running      = running_reg;
        status.sum_zero     = (ring_sum == '0);
        status.secs_zero    = (secs_reg == '0);
        status.mean_over    = (trip_reg[wsd_pkg::DistW-1:wsd_pkg::DivW] >= secs_reg);
        status.div_done     = div_done;
    end

    always_comb
    begin
        ring_next  = ring_reg;
        pos_next   = pos_reg;
        speed_next = speed_reg;
        peak_next  = peak_reg;
        mean_next  = mean_reg;
        trip_next  = trip_reg;
        total_next = total_reg;
        rev_next   = rev_reg;
        clock_next = clock_reg;

        if (cmd.exec)
        begin
            if (cmd_reg == wsd_pkg::CmdSpeedReset)
            begin
                speed_next = '0;
                for (int i = 0; i < wsd_pkg::RingDepth; i++)
                begin
                    ring_next[i] = '0;
                end
            end
            else
            begin
                rev_next           = rev_reg + wsd_pkg::RevW'(1);
                ring_next[pos_reg] = ticks_reg;
                pos_next           = pos_reg + wsd_pkg::RingIdxW'(1);
                if (timeout)
                begin
                    clock_next = clock_reg + wsd_pkg::TimeoutAdvance;
                    speed_next = '0;
                end
                else
                begin
                    clock_next = clock_reg + ticks_reg;
                end
                if (running_reg)
                begin
                    trip_next  = trip_reg + wsd_pkg::DistW'(circumference);
                    total_next = total_reg + wsd_pkg::DistW'(circumference);
                end
            end
        end

        if (cmd.speed_saturate)
        begin
            speed_next = wsd_pkg::SpeedMax;
        end
        if (cmd.speed_from_div)
        begin
            speed_next = div_quotient;
        end
        if (cmd.peak_update && (speed_reg > peak_reg))
        begin
            peak_next = speed_reg;
        end
        if (cmd.mean_zero)
        begin
            mean_next = '0;
        end
        if (cmd.mean_saturate)
        begin
            mean_next = wsd_pkg::SpeedMax;
        end
        if (cmd.mean_from_div)
        begin
            mean_next = div_quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wsd_pkg::RingDepth; i++)
            begin
                ring_reg[i] <= wsd_pkg::MaxRotationTicks;
            end
            pos_reg   <= '0;
            speed_reg <= '0;
            peak_reg  <= '0;
            mean_reg  <= '0;
            trip_reg  <= '0;
            total_reg <= '0;
            rev_reg   <= '0;
            clock_reg <= '0;
        end
        else
        begin
            ring_reg  <= ring_next;
            pos_reg   <= pos_next;
            speed_reg <= speed_next;
            peak_reg  <= peak_next;
            mean_reg  <= mean_next;
            trip_reg  <= trip_next;
            total_reg <= total_next;
            rev_reg   <= rev_next;
            clock_reg <= clock_next;
        end
    end

    // input capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg     <= in_command;
            ticks_reg   <= in_rotation_ticks;
            running_reg <= in_trip_running;
            secs_reg    <= in_trip_seconds;
        end
        if (cmd.out_load)
        begin
            current_speed    <= speed_reg;
            max_speed        <= peak_reg;
            average_speed    <= mean_reg;
            trip_distance    <= trip_reg;
            total_distance   <= total_reg;
            revolution_count <= rev_reg;
            wheel_clock      <= clock_reg;
        end
    end

endmodule

// ===== rtl/wsd_ctrl.sv =====
// Controller FSM: sequences update, speed divide, peak/mean, and result hand-off.
// Depends on wsd_pkg.
module wsd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  wsd_pkg::dp_status_t  status,
    output wsd_pkg::dp_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SPEED_START,
        ST_SPEED_WAIT,
        ST_PEAK,
        ST_MEAN_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.is_reset_cmd)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.timeout)
                begin
                    state_next = ST_PEAK;
                end
                else
                begin
                    state_next = ST_SPEED_START;
                end
            end
            ST_SPEED_START:
            begin
                if (status.sum_zero)
                begin
                    cmd.speed_saturate = 1'b1;
                    state_next         = ST_PEAK;
                end
                else
                begin
                    cmd.speed_div_start = 1'b1;
                    state_next          = ST_SPEED_WAIT;
                end
            end
            ST_SPEED_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.speed_from_div = 1'b1;
                    state_next         = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                if (!status.running)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.peak_update = 1'b1;
                    if (status.secs_zero)
                    begin
                        cmd.mean_zero = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    else if (status.mean_over)
                    begin
                        cmd.mean_saturate = 1'b1;
                        state_next        = ST_FINISH;
                    end
                    else
                    begin
                        cmd.mean_div_start = 1'b1;
                        state_next         = ST_MEAN_WAIT;
                    end
                end
            end
            ST_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.mean_from_div = 1'b1;
                    state_next        = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/wheel_speed_distance_tracker_top.sv =====
// Top level of the wheel speed / distance tracker: stream ports, APB register.
// Depends on wsd_pkg, wsd_ctrl, wsd_dp (and wsd_div below it).
//
//   Channel   Dir  Handshake               Carries
//   s_axis    in   tvalid/tready           one command: revolution or speed reset
//   m_axis    out  tvalid/tready           one result per command: speeds, distances
//   apb       in   psel/penable/pready     wheel_circumference_mm at byte address 0
//
// A speed-reset command goes from acceptance through the exec and finish states to the
// output register. A revolution runs up to two 24-step restoring divides (speed,
// then average) on one shared divider; a timed-out revolution
// skips the speed divide, a stopped trip the average divide.
// One command is in flight at a time; the next is taken as soon as the
// controller is idle, even while the previous result still waits in the
// output register. A stalled m_axis holds the finished result and the FSM.
// Reset (rst_n low, asynchronous) loads the ring with the timeout value,
// clears counters, distances and speeds, and sets the circumference to 2100.
module wheel_speed_distance_tracker_top (
    input  logic          clk,
    input  logic          rst_n,
    // s_axis
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [15:0] rotation_ticks, [16] trip_running, [40:17] trip_seconds, [47:41] zero
    input  logic [47:0]   s_axis_tdata,
    // [0] command
    input  logic [0:0]    s_axis_tuser,
    // m_axis
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [23:0] current_speed, [47:24] max_speed, [71:48] average_speed,
    // [119:72] trip_distance, [167:120] total_distance,
    // [199:168] revolution_count, [215:200] wheel_clock
    output logic [215:0]  m_axis_tdata,
    // APB
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [wsd_pkg::CircW-1:0] circ_reg;
    logic                      circ_sel;

    wsd_pkg::dp_cmd_t          cmd;
    wsd_pkg::dp_status_t       status;

    logic [wsd_pkg::SpeedW-1:0] current_speed;
    logic [wsd_pkg::SpeedW-1:0] max_speed;
    logic [wsd_pkg::SpeedW-1:0] average_speed;
    logic [wsd_pkg::DistW-1:0]  trip_distance;
    logic [wsd_pkg::DistW-1:0]  total_distance;
    logic [wsd_pkg::RevW-1:0]   revolution_count;
    logic [wsd_pkg::TicksW-1:0] wheel_clock;

    // Register file: one word, decoded on paddr[2]; byte offset ignored.
    assign pready   = 1'b1;
    assign circ_sel = (paddr[2] == wsd_pkg::RegWheelCircumference);
    assign prdata   = circ_sel ? {20'd0, circ_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg <= wsd_pkg::CircReset;
        end
        else if (psel && penable && pwrite && pready && circ_sel)
        begin
            circ_reg <= pwdata[wsd_pkg::CircW-1:0];
        end
    end

    wsd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    wsd_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .circumference     (circ_reg),
        .in_command        (s_axis_tuser[0]),
        .in_rotation_ticks (s_axis_tdata[15:0]),
        .in_trip_running   (s_axis_tdata[16]),
        .in_trip_seconds   (s_axis_tdata[40:17]),
        .current_speed     (current_speed),
        .max_speed         (max_speed),
        .average_speed     (average_speed),
        .trip_distance     (trip_distance),
        .total_distance    (total_distance),
        .revolution_count  (revolution_count),
        .wheel_clock       (wheel_clock)
    );

    assign m_axis_tdata = {wheel_clock, revolution_count, total_distance, trip_distance,
                           average_speed, max_speed, current_speed};

endmodule

// ===== rtl/wsd_chk.sv =====
// Port-level checker for the wheel speed / distance tracker, bound to the top.
// Depends on wsd_pkg for the register map.
module wsd_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [215:0]  m_axis_tdata,
    input logic          psel,
    input logic          penable,
    input logic          pwrite,
    input logic [2:0]    paddr,
    input logic [31:0]   pwdata,
    input logic [31:0]   prdata,
    input logic          pready
);

    // stalled result must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // one command at a time: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a command is in flight");

    // trip and total distance always advance together
    a_dist_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[119:72] == m_axis_tdata[167:120])
        else $error("trip and total distance diverged");

    // a circumference write reads back on the next cycle
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == wsd_pkg::RegWheelCircumference)
        |=> (paddr[2] != wsd_pkg::RegWheelCircumference)
            || (prdata[11:0] == $past(pwdata[11:0])))
        else $error("circumference register readback mismatch");

endmodule

bind wheel_speed_distance_tracker_top wsd_chk u_wsd_chk (.*);
